>>> hdl/complex_decimating_fir_unit_assert.svh
// Assertion macros for the complex decimating FIR unit.
`ifndef COMPLEX_DECIMATING_FIR_UNIT_ASSERT_SVH
`define COMPLEX_DECIMATING_FIR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CDF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CDF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cdf_pkg.sv
package cdf_pkg;

    // Filter dimensions and number formats
    localparam int NUM_TAPS       = 64;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int MAX_DECIMATION = 64;

    // Fixed field widths of the channels and the register
    localparam int CMD_BITS       = 2;
    localparam int TAP_INDEX_BITS = 6;
    localparam int DEC_W          = 7;
    localparam logic [DEC_W-1:0] DEC_RESET = DEC_W'(1);

    // Derived widths
    localparam int TAP_W      = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int HIST_DEPTH = 2 ** TAP_W;
    localparam int PHASE_W    = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
    localparam int CMP_W      = (DEC_W > PHASE_W + 1) ? DEC_W : PHASE_W + 2;
    localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W      = PROD_W + TAP_W;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Command codes on the request channel
    localparam logic [CMD_BITS-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_LOAD,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                           op;
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
        logic [TAP_INDEX_BITS-1:0]     tap_index;
        logic signed [COEF_BITS-1:0]   tap_value;
    } q_entry_t;

    typedef struct packed {
        logic     vld;
        q_entry_t data;
    } q_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic mac_busy;
        logic rounding;
    } back_stat_t;

endpackage

>>> hdl/cdf_item_if.sv
interface cdf_item_if;
    logic                                   valid;
    logic                                   ready;
    logic [cdf_pkg::CMD_BITS-1:0]           command;
    logic signed [cdf_pkg::SAMPLE_BITS-1:0] sample_re;
    logic signed [cdf_pkg::SAMPLE_BITS-1:0] sample_im;
    logic [cdf_pkg::TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [cdf_pkg::COEF_BITS-1:0]   tap_value;

    modport source (
        output valid, command, sample_re, sample_im, tap_index, tap_value,
        input  ready
    );
    modport sink (
        input  valid, command, sample_re, sample_im, tap_index, tap_value,
        output ready
    );
endinterface

>>> hdl/cdf_result_if.sv
interface cdf_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cdf_pkg::SAMPLE_BITS-1:0] out_re;
    logic signed [cdf_pkg::SAMPLE_BITS-1:0] out_im;
    logic                                   saturated;

    modport source (
        output valid, out_re, out_im, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_re, out_im, saturated,
        output ready
    );
endinterface

>>> hdl/cdf_front.sv
module cdf_front (
    input  logic              clk,
    input  logic              rst_n,
    cdf_item_if.sink          items,
    input  cdf_pkg::q_stat_t  q_stat,
    output cdf_pkg::q_wr_t    q_wr
);

    logic              stg_vld_reg;
    logic              stg_vld_next;
    cdf_pkg::q_entry_t stg_reg;
    cdf_pkg::q_entry_t stg_next;
    logic              accept;
    logic              keep;
    cdf_pkg::op_t      op;

    // Take a new request whenever the stage is empty or drains this cycle
    assign items.ready = !stg_vld_reg || !q_stat.full;
    assign accept      = items.valid && items.ready;

    assign q_wr.vld  = stg_vld_reg && !q_stat.full;
    assign q_wr.data = stg_reg;

    // Classify the command; drop the unused code
    always_comb
    begin
        op   = cdf_pkg::OP_PUSH;
        keep = 1'b1;
        case (items.command)
            cdf_pkg::CMD_PUSH:  op = cdf_pkg::OP_PUSH;
            cdf_pkg::CMD_LOAD:  op = cdf_pkg::OP_LOAD;
            cdf_pkg::CMD_CLEAR: op = cdf_pkg::OP_CLEAR;
            default:            keep = 1'b0;
        endcase
    end

    // Advance the holding stage
    always_comb
    begin
        stg_vld_next = stg_vld_reg;
        stg_next     = stg_reg;
        if (accept)
        begin
            stg_vld_next       = keep;
            stg_next.op        = op;
            stg_next.sample_re = items.sample_re;
            stg_next.sample_im = items.sample_im;
            stg_next.tap_index = items.tap_index;
            stg_next.tap_value = items.tap_value;
        end
        else if (q_wr.vld)
        begin
            stg_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
        end
        else
        begin
            stg_vld_reg <= stg_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_reg <= stg_next;
    end

endmodule

>>> hdl/cdf_queue.sv
module cdf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  cdf_pkg::q_wr_t     wr,
    input  logic               pop,
    output cdf_pkg::q_entry_t  head,
    output cdf_pkg::q_stat_t   stat
);

    cdf_pkg::q_entry_t          entries [cdf_pkg::QUEUE_DEPTH];
    logic [cdf_pkg::QPTR_W:0]   wr_ptr_reg;
    logic [cdf_pkg::QPTR_W:0]   wr_ptr_next;
    logic [cdf_pkg::QPTR_W:0]   rd_ptr_reg;
    logic [cdf_pkg::QPTR_W:0]   rd_ptr_next;
    logic [cdf_pkg::QPTR_W:0]   ptr_diff;

    // Full when the pointers differ only in the wrap bit
    assign ptr_diff   = wr_ptr_reg ^ rd_ptr_reg;
    assign stat.empty = (ptr_diff == '0);
    assign stat.full  = (ptr_diff == {1'b1, {cdf_pkg::QPTR_W{1'b0}}});
    assign head       = entries[rd_ptr_reg[cdf_pkg::QPTR_W-1:0]];

    assign wr_ptr_next = wr.vld ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop    ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (wr.vld)
        begin
            entries[wr_ptr_reg[cdf_pkg::QPTR_W-1:0]] <= wr.data;
        end
    end

endmodule

>>> hdl/cdf_back.sv
module cdf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cdf_pkg::DEC_W-1:0]     decimation,
    input  cdf_pkg::q_entry_t             head,
    input  cdf_pkg::q_stat_t              q_stat,
    output logic                          pop,
    output cdf_pkg::back_stat_t           bk_stat,
    cdf_result_if.source                  results
);

    localparam int SB     = cdf_pkg::SAMPLE_BITS;
    localparam int CB     = cdf_pkg::COEF_BITS;
    localparam int TW     = cdf_pkg::TAP_W;
    localparam int AW     = cdf_pkg::ACC_W;
    localparam int RS_W   = AW + 1 - (CB - 1);
    localparam int CW     = cdf_pkg::CMP_W;
    localparam int PW     = cdf_pkg::PHASE_W;
    localparam logic signed [AW:0]     RND    = (AW + 1)'(1) <<< (CB - 2);
    localparam logic signed [RS_W-1:0] SAT_HI = RS_W'((1 << (SB - 1)) - 1);
    localparam logic signed [RS_W-1:0] SAT_LO = -SAT_HI - RS_W'(1);
    localparam logic [CW-1:0]          DEC_MAX = CW'(cdf_pkg::MAX_DECIMATION);
    localparam logic [TW-1:0]          LAST_TAP = TW'(cdf_pkg::NUM_TAPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } state_t;

    // Round half up, then clip to the sample range; top bit flags a clip
    function automatic logic [SB:0] rnd_sat(input logic signed [AW-1:0] a);
        logic signed [AW:0]     sum;
        logic signed [AW:0]     shf;
        logic signed [RS_W-1:0] r;
        logic [SB:0]            res;
        sum = (AW + 1)'(a) + RND;
        shf = sum >>> (CB - 1);
        r   = shf[RS_W-1:0];
        if (r > SAT_HI)
        begin
            res = {1'b1, SAT_HI[SB-1:0]};
        end
        else if (r < SAT_LO)
        begin
            res = {1'b1, SAT_LO[SB-1:0]};
        end
        else
        begin
            res = {1'b0, r[SB-1:0]};
        end
        return res;
    endfunction

    // Memories
    logic signed [CB-1:0]   coef_mem [cdf_pkg::NUM_TAPS];
    logic [2*SB-1:0]        hist_mem [cdf_pkg::HIST_DEPTH];

    // Control and pipeline registers
    state_t                 state_reg, state_next;
    logic [TW-1:0]          tap_reg, tap_next;
    logic [TW-1:0]          wp_reg, wp_next;
    logic [PW-1:0]          phase_reg, phase_next;
    logic signed [SB-1:0]   cur_re_reg, cur_re_next;
    logic signed [SB-1:0]   cur_im_reg, cur_im_next;
    logic                   s1_vld_reg, s1_vld_next;
    logic                   s1_first_reg, s1_first_next;
    logic                   s2_vld_reg, s2_vld_next;
    logic                   coef_ok_reg;
    logic                   hist_ok_reg;
    logic signed [CB-1:0]   coef_rd_reg;
    logic [2*SB-1:0]        hist_rd_reg;
    logic signed [cdf_pkg::PROD_W-1:0] prod_re_reg, prod_re_next;
    logic signed [cdf_pkg::PROD_W-1:0] prod_im_reg, prod_im_next;
    logic signed [AW-1:0]   acc_re_reg, acc_re_next;
    logic signed [AW-1:0]   acc_im_reg, acc_im_next;
    logic                   out_vld_reg, out_vld_next;
    logic signed [SB-1:0]   out_re_reg, out_re_next;
    logic signed [SB-1:0]   out_im_reg, out_im_next;
    logic                   out_sat_reg, out_sat_next;
    logic [cdf_pkg::NUM_TAPS-1:0]   coef_vld_reg, coef_vld_next;
    logic [cdf_pkg::HIST_DEPTH-1:0] hist_vld_reg, hist_vld_next;

    // Combinational helpers
    logic [CW-1:0]          dec_ext;
    logic [CW-1:0]          dec_eff;
    logic [CW-1:0]          phase_inc;
    logic [PW-1:0]          phase_adv;
    logic [TW-1:0]          rd_hist_addr;
    logic                   coef_we;
    logic [TW-1:0]          coef_waddr;
    logic                   hist_we;
    logic [2*SB-1:0]        hist_wdata;
    logic signed [CB-1:0]   c_op;
    logic signed [SB-1:0]   x_re_op;
    logic signed [SB-1:0]   x_im_op;
    logic [SB:0]            rs_re;
    logic [SB:0]            rs_im;
    logic                   out_free;

    assign results.valid     = out_vld_reg;
    assign results.out_re    = out_re_reg;
    assign results.out_im    = out_im_reg;
    assign results.saturated = out_sat_reg;

    assign bk_stat.mac_busy = (state_reg == ST_MAC) || (state_reg == ST_DRAIN);
    assign bk_stat.rounding = (state_reg == ST_ROUND);

    // Clamp the decimation factor and advance the phase
    assign dec_ext   = CW'(decimation);
    assign dec_eff   = (dec_ext == '0) ? CW'(1) : ((dec_ext > DEC_MAX) ? DEC_MAX : dec_ext);
    assign phase_inc = CW'(phase_reg) + CW'(1);
    assign phase_adv = (phase_inc >= dec_eff) ? '0 : PW'(phase_inc);

    assign rd_hist_addr = wp_reg - tap_reg;
    assign coef_waddr   = TW'(head.tap_index);
    assign out_free     = !out_vld_reg || results.ready;

    // Multiplier operands: tap zero takes the new sample, stale entries read as zero
    assign c_op    = coef_ok_reg ? coef_rd_reg : '0;
    assign x_re_op = s1_first_reg ? cur_re_reg
                   : (hist_ok_reg ? $signed(hist_rd_reg[2*SB-1:SB]) : '0);
    assign x_im_op = s1_first_reg ? cur_im_reg
                   : (hist_ok_reg ? $signed(hist_rd_reg[SB-1:0]) : '0);
    assign prod_re_next = c_op * x_re_op;
    assign prod_im_next = c_op * x_im_op;

    assign rs_re = rnd_sat(acc_re_reg);
    assign rs_im = rnd_sat(acc_im_reg);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        wp_next       = wp_reg;
        phase_next    = phase_reg;
        cur_re_next   = cur_re_reg;
        cur_im_next   = cur_im_reg;
        s1_vld_next   = 1'b0;
        s1_first_next = 1'b0;
        s2_vld_next   = s1_vld_reg;
        acc_re_next   = acc_re_reg;
        acc_im_next   = acc_im_reg;
        out_vld_next  = out_vld_reg && !results.ready;
        out_re_next   = out_re_reg;
        out_im_next   = out_im_reg;
        out_sat_next  = out_sat_reg;
        coef_vld_next = coef_vld_reg;
        hist_vld_next = hist_vld_reg;
        pop           = 1'b0;
        coef_we       = 1'b0;
        hist_we       = 1'b0;
        hist_wdata    = {cur_re_reg, cur_im_reg};

        // Accumulate products leaving the multiplier stage
        if (s2_vld_reg)
        begin
            acc_re_next = acc_re_reg + AW'(prod_re_reg);
            acc_im_next = acc_im_reg + AW'(prod_im_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    case (head.op)
                        cdf_pkg::OP_LOAD:
                        begin
                            if (int'(head.tap_index) < cdf_pkg::NUM_TAPS)
                            begin
                                coef_we                   = 1'b1;
                                coef_vld_next[coef_waddr] = 1'b1;
                            end
                        end
                        cdf_pkg::OP_CLEAR:
                        begin
                            hist_vld_next = '0;
                            phase_next    = '0;
                        end
                        cdf_pkg::OP_PUSH:
                        begin
                            if (phase_reg != '0)
                            begin
                                hist_we               = 1'b1;
                                hist_wdata            = {head.sample_re, head.sample_im};
                                hist_vld_next[wp_reg] = 1'b1;
                                wp_next               = wp_reg + 1'b1;
                                phase_next            = phase_adv;
                            end
                            else
                            begin
                                cur_re_next = head.sample_re;
                                cur_im_next = head.sample_im;
                                tap_next    = '0;
                                acc_re_next = '0;
                                acc_im_next = '0;
                                state_next  = ST_MAC;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                s1_vld_next   = 1'b1;
                s1_first_next = (tap_reg == '0);
                if (tap_reg == LAST_TAP)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    out_vld_next          = 1'b1;
                    out_re_next           = rs_re[SB-1:0];
                    out_im_next           = rs_im[SB-1:0];
                    out_sat_next          = rs_re[SB] || rs_im[SB];
                    hist_we               = 1'b1;
                    hist_vld_next[wp_reg] = 1'b1;
                    wp_next               = wp_reg + 1'b1;
                    phase_next            = phase_adv;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, pipeline and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tap_reg      <= '0;
            wp_reg       <= '0;
            phase_reg    <= '0;
            cur_re_reg   <= '0;
            cur_im_reg   <= '0;
            s1_vld_reg   <= 1'b0;
            s1_first_reg <= 1'b0;
            s2_vld_reg   <= 1'b0;
            coef_ok_reg  <= 1'b0;
            hist_ok_reg  <= 1'b0;
            prod_re_reg  <= '0;
            prod_im_reg  <= '0;
            acc_re_reg   <= '0;
            acc_im_reg   <= '0;
            out_vld_reg  <= 1'b0;
            out_re_reg   <= '0;
            out_im_reg   <= '0;
            out_sat_reg  <= 1'b0;
            coef_vld_reg <= '0;
            hist_vld_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            wp_reg       <= wp_next;
            phase_reg    <= phase_next;
            cur_re_reg   <= cur_re_next;
            cur_im_reg   <= cur_im_next;
            s1_vld_reg   <= s1_vld_next;
            s1_first_reg <= s1_first_next;
            s2_vld_reg   <= s2_vld_next;
            coef_ok_reg  <= coef_vld_reg[tap_reg];
            hist_ok_reg  <= hist_vld_reg[rd_hist_addr];
            prod_re_reg  <= prod_re_next;
            prod_im_reg  <= prod_im_next;
            acc_re_reg   <= acc_re_next;
            acc_im_reg   <= acc_im_next;
            out_vld_reg  <= out_vld_next;
            out_re_reg   <= out_re_next;
            out_im_reg   <= out_im_next;
            out_sat_reg  <= out_sat_next;
            coef_vld_reg <= coef_vld_next;
            hist_vld_reg <= hist_vld_next;
        end
    end

    // Coefficient and history memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= head.tap_value;
        end
        if (hist_we)
        begin
            hist_mem[wp_reg] <= hist_wdata;
        end
        coef_rd_reg <= coef_mem[tap_reg];
        hist_rd_reg <= hist_mem[rd_hist_addr];
    end

endmodule

>>> hdl/complex_decimating_fir_unit.sv
// The back end handles a load, a clear or a push at a nonzero phase from its idle state; a push
// at phase zero gives a result and holds the back end through its MAC, drain and round states,
// one tap per cycle through the shared I/Q multiplier pair, while a two-entry queue
// keeps taking requests.
// Reset: control state clears at once; coefficients and history read as zero through
// per-entry valid bits, phase is zero and decimation is one; there is no clearing pass.
module complex_decimating_fir_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    cdf_item_if.sink                    items,
    cdf_result_if.source                results,
    input  logic                        cfg_we,
    input  logic [cdf_pkg::DEC_W-1:0]   cfg_wdata
);

`include "complex_decimating_fir_unit_assert.svh"

    logic [cdf_pkg::DEC_W-1:0] dec_reg;
    logic [cdf_pkg::DEC_W-1:0] dec_next;
    cdf_pkg::q_wr_t            q_wr;
    cdf_pkg::q_stat_t          q_stat;
    cdf_pkg::q_entry_t         q_head;
    logic                      q_pop;
    cdf_pkg::back_stat_t       bk_stat;

    // Hold the decimation register
    assign dec_next = cfg_we ? cfg_wdata : dec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= cdf_pkg::DEC_RESET;
        end
        else
        begin
            dec_reg <= dec_next;
        end
    end

    cdf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .q_stat (q_stat),
        .q_wr   (q_wr)
    );

    cdf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .pop   (q_pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    cdf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .decimation (dec_reg),
        .head       (q_head),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .bk_stat    (bk_stat),
        .results    (results)
    );

    `CDF_ASSERT_IMP(a_no_overflow, q_wr.vld, !q_stat.full, "request queue written while full")
    `CDF_ASSERT_IMP(a_no_underflow, q_pop, !q_stat.empty, "request queue read while empty")
    `CDF_ASSERT_IMP(a_no_pop_in_mac, bk_stat.mac_busy, !q_pop, "request taken during a MAC run")
    `CDF_ASSERT_IMP(a_result_from_round, $rose(results.valid), $past(bk_stat.rounding),
        "result appeared without a rounding step")

endmodule

>>> dv/complex_decimating_fir_unit_tb.sv
module complex_decimating_fir_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Command three has no meaning in the block and must be dropped
    localparam logic [cdf_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    localparam longint SAMPLE_MAX      = (longint'(1) <<< (cdf_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN      = -SAMPLE_MAX - 1;
    localparam int     SETTLE_CYCLES   = 3 * (cdf_pkg::NUM_TAPS + 8);
    localparam int     ITEMS_PER_PHASE = 188;
    localparam int     NUM_PHASES      = 8;
    localparam int     DRAIN_GUARD     = 200000;
    localparam int     MAX_PRINTS      = 40;

    typedef struct {
        logic [cdf_pkg::CMD_BITS-1:0]           command;
        logic signed [cdf_pkg::SAMPLE_BITS-1:0] sample_re;
        logic signed [cdf_pkg::SAMPLE_BITS-1:0] sample_im;
        logic [cdf_pkg::TAP_INDEX_BITS-1:0]     tap_index;
        logic signed [cdf_pkg::COEF_BITS-1:0]   tap_value;
    } fir_req_t;

    typedef struct {
        logic signed [cdf_pkg::SAMPLE_BITS-1:0] out_re;
        logic signed [cdf_pkg::SAMPLE_BITS-1:0] out_im;
        logic                                   saturated;
    } fir_out_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [cdf_pkg::DEC_W-1:0] cfg_wdata;

    cdf_item_if   items_if ();
    cdf_result_if results_if ();

    complex_decimating_fir_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow state of the filter
    logic signed [cdf_pkg::COEF_BITS-1:0]   coef_bank [cdf_pkg::NUM_TAPS];
    logic signed [cdf_pkg::SAMPLE_BITS-1:0] window_re [cdf_pkg::NUM_TAPS];
    logic signed [cdf_pkg::SAMPLE_BITS-1:0] window_im [cdf_pkg::NUM_TAPS];
    int unsigned                            phase_ctr;
    logic [cdf_pkg::DEC_W-1:0]              dec_shadow;

    fir_req_t pending_reqs [$];
    fir_out_t predicted_outputs [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int reqs_taken     = 0;
    int outputs_seen   = 0;
    int clipped_seen   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Round half up, drop the fraction bits, clip to the sample range
    function automatic logic signed [cdf_pkg::SAMPLE_BITS-1:0] round_sat(input longint acc,
                                                                          inout bit clip);
        longint r;
        r = (acc + (longint'(1) <<< (cdf_pkg::COEF_BITS - 2))) >>> (cdf_pkg::COEF_BITS - 1);
        if (r > SAMPLE_MAX)
        begin
            clip = 1'b1;
            r = SAMPLE_MAX;
        end
        else if (r < SAMPLE_MIN)
        begin
            clip = 1'b1;
            r = SAMPLE_MIN;
        end
        return r[cdf_pkg::SAMPLE_BITS-1:0];
    endfunction

    // Advance the shadow filter by one accepted request
    task automatic compute_fir_step(input fir_req_t req);
        longint      acc_re;
        longint      acc_im;
        bit          clip;
        int unsigned eff_dec;
        fir_out_t    res;
        case (req.command)
            cdf_pkg::CMD_LOAD:
                coef_bank[req.tap_index] = req.tap_value;
            cdf_pkg::CMD_CLEAR:
            begin
                for (int j = 0; j < cdf_pkg::NUM_TAPS; j++)
                begin
                    window_re[j] = '0;
                    window_im[j] = '0;
                end
                phase_ctr = 0;
            end
            cdf_pkg::CMD_PUSH:
            begin
                eff_dec = (dec_shadow == 0) ? 1 :
                          (dec_shadow > cdf_pkg::MAX_DECIMATION) ? cdf_pkg::MAX_DECIMATION
                                                                 : dec_shadow;
                for (int j = cdf_pkg::NUM_TAPS - 1; j > 0; j--)
                begin
                    window_re[j] = window_re[j-1];
                    window_im[j] = window_im[j-1];
                end
                window_re[0] = req.sample_re;
                window_im[0] = req.sample_im;
                if (phase_ctr == 0)
                begin
                    acc_re = 0;
                    acc_im = 0;
                    clip   = 1'b0;
                    for (int j = 0; j < cdf_pkg::NUM_TAPS; j++)
                    begin
                        acc_re += longint'(coef_bank[j]) * longint'(window_re[j]);
                        acc_im += longint'(coef_bank[j]) * longint'(window_im[j]);
                    end
                    res.out_re    = round_sat(acc_re, clip);
                    res.out_im    = round_sat(acc_im, clip);
                    res.saturated = clip;
                    predicted_outputs.push_back(res);
                end
                phase_ctr++;
                if (phase_ctr >= eff_dec)
                    phase_ctr = 0;
            end
            default: ;
        endcase
    endtask

    // Driver: hold a request until taken, otherwise present the next one or idle
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        fir_req_t taken;
        if (!rst_n)
        begin
            items_if.valid     <= 1'b0;
            items_if.command   <= cdf_pkg::CMD_PUSH;
            items_if.sample_re <= '0;
            items_if.sample_im <= '0;
            items_if.tap_index <= '0;
            items_if.tap_value <= '0;
        end
        else
        begin
            if (items_if.valid && items_if.ready)
            begin
                taken = pending_reqs.pop_front();
                compute_fir_step(taken);
                reqs_taken++;
            end
            if (!items_if.valid || items_if.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    items_if.valid     <= 1'b1;
                    items_if.command   <= pending_reqs[0].command;
                    items_if.sample_re <= pending_reqs[0].sample_re;
                    items_if.sample_im <= pending_reqs[0].sample_im;
                    items_if.tap_index <= pending_reqs[0].tap_index;
                    items_if.tap_value <= pending_reqs[0].tap_value;
                end
                else
                    items_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each taken output against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        fir_out_t exp_out;
        if (!rst_n)
            results_if.ready <= 1'b0;
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                outputs_seen++;
                if (results_if.saturated)
                    clipped_seen++;
                if (predicted_outputs.size() == 0)
                    report_mismatch($sformatf("unexpected output re=%0d im=%0d sat=%0b",
                        results_if.out_re, results_if.out_im, results_if.saturated));
                else
                begin
                    exp_out = predicted_outputs.pop_front();
                    if (results_if.out_re !== exp_out.out_re)
                        report_mismatch($sformatf("out_re got %0d want %0d",
                            results_if.out_re, exp_out.out_re));
                    if (results_if.out_im !== exp_out.out_im)
                        report_mismatch($sformatf("out_im got %0d want %0d",
                            results_if.out_im, exp_out.out_im));
                    if (results_if.saturated !== exp_out.saturated)
                        report_mismatch($sformatf("saturated got %0b want %0b",
                            results_if.saturated, exp_out.saturated));
                end
            end
            results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_req(input logic [cdf_pkg::CMD_BITS-1:0] cmd, input longint re,
                           input longint im, input int idx, input longint val);
        fir_req_t req;
        req.command   = cmd;
        req.sample_re = re[cdf_pkg::SAMPLE_BITS-1:0];
        req.sample_im = im[cdf_pkg::SAMPLE_BITS-1:0];
        req.tap_index = idx[cdf_pkg::TAP_INDEX_BITS-1:0];
        req.tap_value = val[cdf_pkg::COEF_BITS-1:0];
        pending_reqs.push_back(req);
    endtask

    function automatic logic signed [cdf_pkg::SAMPLE_BITS-1:0] random_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return cdf_pkg::SAMPLE_BITS'($urandom);
        if (roll < 85)
            return cdf_pkg::SAMPLE_BITS'($urandom_range(512) - 256);
        case ($urandom_range(3))
            0:       return SAMPLE_MIN[cdf_pkg::SAMPLE_BITS-1:0];
            1:       return SAMPLE_MAX[cdf_pkg::SAMPLE_BITS-1:0];
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Mostly pushes, with coefficient updates, rare clears and dropped commands
    function automatic fir_req_t random_request();
        fir_req_t req;
        int       roll;
        roll          = $urandom_range(99);
        req.command   = (roll < 78) ? cdf_pkg::CMD_PUSH : (roll < 90) ? cdf_pkg::CMD_LOAD :
                        (roll < 95) ? CMD_UNUSED : cdf_pkg::CMD_CLEAR;
        req.sample_re = random_sample();
        req.sample_im = random_sample();
        req.tap_index = cdf_pkg::TAP_INDEX_BITS'($urandom);
        if ($urandom_range(99) < 40)
            req.tap_value = cdf_pkg::COEF_BITS'($urandom);
        else
            req.tap_value = cdf_pkg::COEF_BITS'($urandom_range(8192) - 4096);
        return req;
    endfunction

    // Hold until every request is taken and every output has come, then settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((pending_reqs.size() != 0 || predicted_outputs.size() != 0)
               && guard < DRAIN_GUARD)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_decimation(input logic [cdf_pkg::DEC_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        dec_shadow = value;
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus_proc
        logic [cdf_pkg::DEC_W-1:0] dec_plan [NUM_PHASES];
        fir_out_t                  leftover;
        dec_plan = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd127, 7'd3, 7'd65, 7'd9};

        // Known values on the reset and register inputs before reset releases
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = cdf_pkg::DEC_RESET;
        for (int j = 0; j < cdf_pkg::NUM_TAPS; j++)
        begin
            coef_bank[j] = '0;
            window_re[j] = '0;
            window_im[j] = '0;
        end
        phase_ctr  = 0;
        dec_shadow = cdf_pkg::DEC_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero taps, rounding ties, clipping on the I and Q sides, edge taps
        add_req(cdf_pkg::CMD_PUSH, 1, -1, 0, 0);
        add_req(cdf_pkg::CMD_LOAD, 0, 0, 0, 65536);
        add_req(cdf_pkg::CMD_PUSH, 1, -1, 5, 0);
        add_req(cdf_pkg::CMD_PUSH, 3, -3, 0, 0);
        add_req(cdf_pkg::CMD_LOAD, 0, 0, 0, -131072);
        add_req(cdf_pkg::CMD_PUSH, SAMPLE_MIN, 0, 0, 0);
        add_req(cdf_pkg::CMD_PUSH, 0, SAMPLE_MIN, 0, 0);
        add_req(cdf_pkg::CMD_PUSH, SAMPLE_MAX, SAMPLE_MAX, 0, 0);
        add_req(cdf_pkg::CMD_LOAD, 0, 0, cdf_pkg::NUM_TAPS - 1, 131071);
        add_req(cdf_pkg::CMD_LOAD, 0, 0, 31, -1);
        add_req(cdf_pkg::CMD_PUSH, SAMPLE_MAX, SAMPLE_MIN, 63, 131071);
        add_req(CMD_UNUSED, -5, 7, 0, 99);
        add_req(cdf_pkg::CMD_CLEAR, 1234, -1234, 12, 0);
        add_req(cdf_pkg::CMD_PUSH, -1, 1, 0, 0);
        wait_drained();

        // Lower the decimation below the current phase: the next push wraps
        write_decimation(7'd20);
        repeat (7) add_req(cdf_pkg::CMD_PUSH, random_sample(), random_sample(), 0, 0);
        wait_drained();
        write_decimation(7'd3);
        repeat (3) add_req(cdf_pkg::CMD_PUSH, random_sample(), random_sample(), 0, 0);
        wait_drained();

        // Random phases over decimation settings and idling modes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_decimation(dec_plan[p]);
            @(negedge clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Pause the sender midway until all outputs are back
                if (i == ITEMS_PER_PHASE / 2)
                    wait_drained();
                pending_reqs.push_back(random_request());
            end
            wait_drained();
        end

        while (predicted_outputs.size() != 0)
        begin
            leftover = predicted_outputs.pop_front();
            report_mismatch($sformatf("missing output re=%0d im=%0d sat=%0b",
                leftover.out_re, leftover.out_im, leftover.saturated));
        end

        $display("Ran %0d requests (push, load, clear, dropped) giving %0d outputs, %0d clipped,",
                 reqs_taken, outputs_seen, clipped_seen);
        $display("over decimation 0..127 incl. lowering below phase and four idling modes");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #12_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
